>>> sv/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package wbps_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [2:0] REG_WILDCARD     = 3'd2;
  localparam logic [2:0] REG_LENGTH       = 3'd3;
  localparam logic [2:0] REG_OFFSET       = 3'd4;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int ADDR_W = 64;
  localparam int LEN_CFG_W = 5;

  // Control of the window stage as seen by the compare stage.
  typedef struct packed {
    logic valid;  // a beat sits in the window stage
    logic last;   // that beat closed the scanned range
  } win_ctl_t;

endpackage

`default_nettype wire

>>> sv/wbps_window.sv
// Window stage: sliding window of recent bytes and readable flags.
// Depends on wbps_pkg.
`default_nettype none

module wbps_window #(
  parameter int MAX_BYTES = 16,
  parameter int SW = $clog2(MAX_BYTES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic [wbps_pkg::ADDR_W-1:0]    byte_address,
  input  logic                           byte_readable,
  input  logic                           range_end,
  input  logic [SW-1:0]                  used_len,
  input  logic                           s1_move,
  output wbps_pkg::win_ctl_t             ctl,
  output logic [MAX_BYTES*8-1:0]         win_bytes,
  output logic [MAX_BYTES-1:0]           win_readable,
  output logic [SW-1:0]                  seen,
  output logic [wbps_pkg::ADDR_W-1:0]    start_addr
);
  import wbps_pkg::*;

  logic                 accept;
  logic [MAX_BYTES-1:0] base_readable;
  logic [SW-1:0]        base_seen;
  logic [SW-1:0]        seen_next;
  logic [MAX_BYTES:0]   readable_shift;
  logic [MAX_BYTES*8+7:0] bytes_shift;

  assign in_ready = !ctl.valid || s1_move;
  assign accept   = in_valid && in_ready;

  // A range end clears the scan before the next beat enters.
  assign base_readable  = ctl.last ? '0 : win_readable;
  assign base_seen      = ctl.last ? '0 : seen;
  assign readable_shift = {base_readable, byte_readable};
  assign bytes_shift    = {win_bytes, data_byte};
  assign seen_next = (base_seen == SW'(MAX_BYTES)) ? base_seen : base_seen + SW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= '0;
      win_readable <= '0;
      seen         <= '0;
    end else begin
      if (accept) begin
        ctl.valid    <= 1'b1;
        ctl.last     <= range_end;
        win_readable <= readable_shift[MAX_BYTES-1:0];
        seen         <= seen_next;
      end else if (s1_move) begin
        ctl.valid <= 1'b0;
      end
    end
  end

  // Payload: bytes beyond the seen count never affect a match.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_bytes  <= bytes_shift[MAX_BYTES*8-1:0];
      start_addr <= byte_address - ADDR_W'(used_len - SW'(1));
    end
  end

endmodule

`default_nettype wire

>>> sv/wbps_match.sv
// Compare stage: wildcard compare of the window and the result register.
// Depends on wbps_pkg.
`default_nettype none

module wbps_match #(
  parameter int MAX_BYTES = 16,
  parameter int SW = $clog2(MAX_BYTES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wbps_pkg::win_ctl_t           ctl,
  input  logic [MAX_BYTES*8-1:0]       win_bytes,
  input  logic [MAX_BYTES-1:0]         win_readable,
  input  logic [SW-1:0]                seen,
  input  logic [wbps_pkg::ADDR_W-1:0]  start_addr,
  input  logic [SW-1:0]                used_len,
  input  logic [MAX_BYTES*8-1:0]       pattern,
  input  logic [MAX_BYTES-1:0]         wild,
  input  logic [31:0]                  offset,
  output logic                         s1_move,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         match_found,
  output logic [wbps_pkg::ADDR_W-1:0]  match_address
);
  import wbps_pkg::*;

  // Pattern byte index width.
  localparam int KW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic                 reported;
  logic [MAX_BYTES-1:0] place_ok;
  logic                 hit;
  logic                 emit_hit;
  logic                 emit_miss;
  logic [31:0]          low_sum;

  // Window place p pairs with pattern byte used_len-1-p.
  always_comb begin
    for (int p = 0; p < MAX_BYTES; p++) begin
      logic [KW-1:0] k;
      k = KW'(used_len - SW'(1) - SW'(p));
      if (SW'(p) >= used_len) begin
        place_ok[p] = 1'b1;
      end else begin
        place_ok[p] = win_readable[p] &&
                      (wild[k] || (win_bytes[p*8 +: 8] == pattern[k*8 +: 8]));
      end
    end
  end

  assign hit       = (seen >= used_len) && (&place_ok);
  assign s1_move   = ctl.valid && (!out_valid || out_ready);
  assign emit_hit  = s1_move && !reported && hit;
  assign emit_miss = s1_move && !reported && !hit && ctl.last;
  assign low_sum   = start_addr[31:0] + offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      reported  <= 1'b0;
    end else begin
      if (emit_hit || emit_miss) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_move) begin
        if (ctl.last) begin
          reported <= 1'b0;
        end else if (hit) begin
          reported <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_hit) begin
      match_found   <= 1'b1;
      match_address <= {start_addr[ADDR_W-1:32], low_sum};
    end else if (emit_miss) begin
      match_found   <= 1'b0;
      match_address <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    emit_hit |=> (out_valid && match_found))
    else $error("match not presented");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    emit_miss |=> (out_valid && !match_found && match_address == '0))
    else $error("not-found result malformed");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_move && ctl.last) |=> !reported)
    else $error("range end left scan reported");
  a_no_second: assert property (@(posedge clk) disable iff (rst)
    (s1_move && reported) |-> !(emit_hit || emit_miss))
    else $error("result after match in same range");
`endif

endmodule

`default_nettype wire

>>> sv/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: config registers and stages.
// Depends on wbps_pkg, wbps_window and wbps_match.
`default_nettype none

// Scans a byte stream for a pattern of up to MAX_PATTERN_BYTES bytes with
// per-byte wildcards. One beat per clock is accepted and a beat's result (if
// any) is formed in two register stages: the first shifts the byte into the
// window and precomputes the window start address, the second compares all
// window places in parallel and loads the result register. Sustained rate is
// one beat per cycle; the only stall comes from
// out_ready backpressure, which reaches in_ready through the window stage.
// A window matches when every in-use place is readable and every non-wildcard
// pattern byte is equal. The first match of a range gives match_found=1 and
// the start address with result_offset added to its low 32 bits; a range that
// ends without a match gives match_found=0 and address 0. Later bytes of a
// range that already matched give nothing. A range_end beat clears the scan.
// Pattern length 0 acts as 1, lengths above MAX_PATTERN_BYTES are clamped.
// Configuration writes are taken at any time but must only be made while the
// block is idle.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  input  logic [wbps_pkg::ADDR_W-1:0]        byte_address,
  input  logic                               byte_readable,
  input  logic                               range_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               match_found,
  output logic [wbps_pkg::ADDR_W-1:0]        match_address
);
  import wbps_pkg::*;

  localparam int SW = $clog2(MAX_PATTERN_BYTES + 1);

  // Configuration registers
  logic [63:0]          pattern_bytes_low;
  logic [63:0]          pattern_bytes_high;
  logic [15:0]          wildcard_mask;
  logic [LEN_CFG_W-1:0] pattern_length;
  logic [31:0]          result_offset;

  logic [127:0]                   pattern_all;
  logic [MAX_PATTERN_BYTES*8-1:0] pattern;
  logic [MAX_PATTERN_BYTES-1:0]   wild;
  logic [SW-1:0]                  used_len;

  win_ctl_t                       ctl;
  logic [MAX_PATTERN_BYTES*8-1:0] win_bytes;
  logic [MAX_PATTERN_BYTES-1:0]   win_readable;
  logic [SW-1:0]                  seen;
  logic [ADDR_W-1:0]              start_addr;
  logic                           s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      wildcard_mask      <= '0;
      pattern_length     <= LEN_CFG_W'(1);
      result_offset      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        REG_WILDCARD:     wildcard_mask      <= cfg_data[15:0];
        REG_LENGTH:       pattern_length     <= cfg_data[LEN_CFG_W-1:0];
        REG_OFFSET:       result_offset      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Only the first MAX_PATTERN_BYTES pattern bytes and mask bits are used.
  assign pattern_all = {pattern_bytes_high, pattern_bytes_low};
  assign pattern     = pattern_all[MAX_PATTERN_BYTES*8-1:0];
  assign wild        = wildcard_mask[MAX_PATTERN_BYTES-1:0];

  // Effective length: zero acts as one, clamp to the window depth.
  always_comb begin
    if (pattern_length == '0) begin
      used_len = SW'(1);
    end else if (6'(pattern_length) > 6'(MAX_PATTERN_BYTES)) begin
      used_len = SW'(MAX_PATTERN_BYTES);
    end else begin
      used_len = SW'(pattern_length);
    end
  end

  wbps_window #(
    .MAX_BYTES (MAX_PATTERN_BYTES),
    .SW        (SW)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .byte_address  (byte_address),
    .byte_readable (byte_readable),
    .range_end     (range_end),
    .used_len      (used_len),
    .s1_move       (s1_move),
    .ctl           (ctl),
    .win_bytes     (win_bytes),
    .win_readable  (win_readable),
    .seen          (seen),
    .start_addr    (start_addr)
  );

  wbps_match #(
    .MAX_BYTES (MAX_PATTERN_BYTES),
    .SW        (SW)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .win_bytes     (win_bytes),
    .win_readable  (win_readable),
    .seen          (seen),
    .start_addr    (start_addr),
    .used_len      (used_len),
    .pattern       (pattern),
    .wild          (wild),
    .offset        (result_offset),
    .s1_move       (s1_move),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_found   (match_found),
    .match_address (match_address)
  );

endmodule

`default_nettype wire
